// ===== rtl/apfd_pkg.sv =====
package apfd_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND = 1'd1;

	typedef enum logic [1:0] {
		MODE_CHECK = 2'd0,
		MODE_FIND  = 2'd1,
		MODE_FLAG  = 2'd2,
		MODE_SET   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ODD  = 2'd1,
		KIND_EVEN = 2'd2,
		KIND_MARK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		V_OK        = 3'd0,
		V_ERROR     = 3'd1,
		V_UNDET     = 3'd2,
		V_NONE      = 3'd3,
		V_ODD       = 3'd4,
		V_EVEN      = 3'd5,
		V_MARK      = 3'd6,
		V_EIGHT_BIT = 3'd7
	} verdict_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        byte_ok;
		verdict_t    verdict;
		logic [31:0] error_total;
		logic [31:0] first_bad_index;
		logic        is_last;
		logic        find_last;
	} res_t;

	function automatic logic byte_matches(logic [7:0] b, kind_t k);
		logic r;
		case (k)
			KIND_NONE: r = ~b[7];
			KIND_ODD:  r = ^b;
			KIND_EVEN: r = ~^b;
			default:   r = b[7];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] byte_with_parity(logic [7:0] b, kind_t k);
		logic [6:0] low;
		logic [7:0] r;
		low = b[6:0];
		case (k)
			KIND_NONE: r = {1'b0, low};
			KIND_ODD:  r = {~^low, low};
			KIND_EVEN: r = {^low, low};
			default:   r = {1'b1, low};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/apfd_if.sv =====
interface apfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_stream;

	modport source (output valid, output byte_in, output end_of_stream, input ready);
	modport sink (input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface apfd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        byte_ok;
	logic [2:0]  verdict;
	logic [31:0] error_total;
	logic [31:0] first_bad_index;
	logic        is_last;

	modport source (output valid, output byte_out, output byte_ok, output verdict,
		output error_total, output first_bad_index, output is_last, input ready);
	modport sink (input valid, input byte_out, input byte_ok, input verdict,
		input error_total, input first_bad_index, input is_last, output ready);
endinterface

// ===== rtl/apfd_byte_unit.sv =====
module apfd_byte_unit #(
	parameter int COUNT_BITS = apfd_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  apfd_pkg::mode_t            mode,
	input  apfd_pkg::kind_t            parity_kind,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 byte_in,
	input  logic                       end_of_stream,
	output logic                       out_valid,
	input  logic                       out_ready,
	output apfd_pkg::res_t             res,
	output logic [3:0][COUNT_BITS-1:0] counts
);
	import apfd_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       eos_s1;
	logic [3:0][COUNT_BITS-1:0] cls_q;
	logic [3:0][COUNT_BITS-1:0] cls_n;
	logic [COUNT_BITS-1:0]      idx_q;
	logic [COUNT_BITS-1:0]      err_q;
	logic [COUNT_BITS-1:0]      err_n;
	logic [COUNT_BITS-1:0]      fbi_q;
	logic [COUNT_BITS-1:0]      fbi_n;
	logic [COUNT_BITS+31:0]     err_ext;
	logic [COUNT_BITS+31:0]     fbi_ext;
	logic [1:0]                 cls;
	logic                       ok;
	logic                       err_mode;
	logic                       take;
	verdict_t                   base;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign take      = valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_stream;
		end
	end

	always_comb begin
		cls      = {byte_s1[7], ^byte_s1};
		ok       = byte_matches(byte_s1, parity_kind);
		err_mode = (mode == MODE_CHECK) || (mode == MODE_FLAG);
		for (int k = 0; k < 4; k++) begin
			if (cls == 2'(k) && cls_q[k] != CNT_MAX) begin
				cls_n[k] = cls_q[k] + 1'b1;
			end else begin
				cls_n[k] = cls_q[k];
			end
		end
		err_n = err_q;
		fbi_n = fbi_q;
		if (err_mode && !ok) begin
			if (err_q == '0) begin
				fbi_n = idx_q;
			end
			if (err_q != CNT_MAX) begin
				err_n = err_q + 1'b1;
			end
		end
		if (!eos_s1) begin
			base = V_OK;
		end else begin
			case (mode)
				MODE_FIND: base = V_UNDET;
				MODE_SET:  base = V_OK;
				default:   base = (err_n == '0) ? V_OK : V_ERROR;
			endcase
		end
		err_ext = {32'b0, err_n};
		fbi_ext = {32'b0, fbi_n};
	end

	always_comb begin
		res.byte_out        = (mode == MODE_SET) ? byte_with_parity(byte_s1, parity_kind)
			: byte_s1;
		res.byte_ok         = ok;
		res.verdict         = base;
		res.error_total     = err_ext[31:0];
		res.first_bad_index = fbi_ext[31:0];
		res.is_last         = eos_s1;
		res.find_last       = eos_s1 && (mode == MODE_FIND);
		counts              = cls_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q <= '0;
			idx_q <= '0;
			err_q <= '0;
			fbi_q <= CNT_MAX;
		end else if (take) begin
			if (eos_s1) begin
				cls_q <= '0;
				idx_q <= '0;
				err_q <= '0;
				fbi_q <= CNT_MAX;
			end else begin
				cls_q <= cls_n;
				err_q <= err_n;
				fbi_q <= fbi_n;
				idx_q <= (idx_q != CNT_MAX) ? idx_q + 1'b1 : idx_q;
			end
		end
	end

endmodule

// ===== rtl/apfd_verdict_pipe.sv =====
module apfd_verdict_pipe #(
	parameter int COUNT_BITS = apfd_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  apfd_pkg::res_t             res_in,
	input  logic [3:0][COUNT_BITS-1:0] counts,
	output logic                       out_valid,
	input  logic                       out_ready,
	output apfd_pkg::res_t             res_out
);
	import apfd_pkg::*;

	localparam int SW = COUNT_BITS + 9;

	function automatic logic [SW-1:0] mul100(logic [SW-1:0] e);
		return (e << 6) + (e << 5) + (e << 2);
	endfunction

	function automatic logic [SW-1:0] mul85(logic [SW-1:0] e);
		return (e << 6) + (e << 4) + (e << 2) + e;
	endfunction

	function automatic logic [SW-1:0] mul30(logic [SW-1:0] e);
		return (e << 4) + (e << 3) + (e << 2) + (e << 1);
	endfunction

	logic                       v_s2, v_s3, v_s4, v_q;
	logic                       acc2, acc3, acc4, acc_o;
	res_t                       res_s2, res_s3, res_s4, res_q, res_n;
	logic [3:0][COUNT_BITS-1:0] cnt_s2, cnt_s3;
	logic [5:0][COUNT_BITS:0]   pair_n, pair_s3;
	logic [COUNT_BITS+1:0]      tot_n, tot_s3;
	logic [5:0][SW-1:0]         pairx_n, pairx_s4;
	logic [3:0][SW-1:0]         clsx_n, clsx_s4;
	logic [SW-1:0]              hi_n, hi_s4, lo_n, lo_s4;
	logic                       all_low;
	verdict_t                   fv;

	assign acc_o     = !v_q || out_ready;
	assign acc4      = !v_s4 || acc_o;
	assign acc3      = !v_s3 || acc4;
	assign acc2      = !v_s2 || acc3;
	assign in_ready  = acc2;
	assign out_valid = v_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (acc2) v_s2 <= in_valid;
			if (acc3) v_s3 <= v_s2;
			if (acc4) v_s4 <= v_s3;
			if (acc_o) v_q <= v_s4;
		end
	end

	always_comb begin
		pair_n[0] = {1'b0, cnt_s2[0]} + {1'b0, cnt_s2[1]};
		pair_n[1] = {1'b0, cnt_s2[0]} + {1'b0, cnt_s2[2]};
		pair_n[2] = {1'b0, cnt_s2[2]} + {1'b0, cnt_s2[3]};
		pair_n[3] = {1'b0, cnt_s2[1]} + {1'b0, cnt_s2[3]};
		pair_n[4] = {1'b0, cnt_s2[0]} + {1'b0, cnt_s2[3]};
		pair_n[5] = {1'b0, cnt_s2[1]} + {1'b0, cnt_s2[2]};
		tot_n     = {1'b0, pair_n[0]} + {1'b0, pair_n[2]};
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pairx_n[k] = mul100(SW'(pair_s3[k]) + SW'(1));
		end
		for (int k = 0; k < 4; k++) begin
			clsx_n[k] = mul100(SW'(cnt_s3[k]) + SW'(1));
		end
		hi_n = mul85(SW'(tot_s3));
		lo_n = mul30(SW'(tot_s3));
	end

	always_comb begin
		all_low = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (clsx_s4[k] > lo_s4) all_low = 1'b0;
		end
		if (pairx_s4[0] > hi_s4) begin
			fv = V_NONE;
		end else if (pairx_s4[1] > hi_s4) begin
			fv = V_EVEN;
		end else if (pairx_s4[2] > hi_s4) begin
			fv = V_MARK;
		end else if (pairx_s4[3] > hi_s4 || pairx_s4[4] > hi_s4 || pairx_s4[5] > hi_s4) begin
			fv = V_ODD;
		end else if (all_low) begin
			fv = V_EIGHT_BIT;
		end else begin
			fv = V_UNDET;
		end
		res_n = res_s4;
		if (res_s4.find_last) begin
			res_n.verdict = fv;
		end
	end

	always_ff @(posedge clk) begin
		if (acc2) begin
			res_s2 <= res_in;
			cnt_s2 <= counts;
		end
		if (acc3) begin
			res_s3  <= res_s2;
			cnt_s3  <= cnt_s2;
			pair_s3 <= pair_n;
			tot_s3  <= tot_n;
		end
		if (acc4) begin
			res_s4   <= res_s3;
			pairx_s4 <= pairx_n;
			clsx_s4  <= clsx_n;
			hi_s4    <= hi_n;
			lo_s4    <= lo_n;
		end
		if (acc_o) begin
			res_q <= res_n;
		end
	end

endmodule

// ===== rtl/ascii_parity_filter_detector_core.sv =====
// Seven-bit ASCII parity generator, checker and detector.
// in_ch carries one stream byte per word with an end_of_stream mark on the
// final byte; out_ch returns exactly one result word per input word, in order.
// Configuration (mode, parity_kind) is written through cfg_we/cfg_index/cfg_data
// by the user only while the block is idle; the block itself does not enforce
// this. It applies to every byte that follows.
// Throughput: one word per cycle while out_ch is not stalled.
// Stages: an input register, the counter update, the pair and total sums,
// the constant scaling for the 85% and 30% thresholds, and the result
// register where the find verdict is chosen.
// Each stage holds its word only while the stage after it is full and stalled,
// so bubbles close up; with out_ch stalled, in_ch accepts until all five
// stages hold a word.
// Reset sets mode to set parity and parity_kind to none, empties every stage,
// clears the class counters, byte index and error counter and sets the first
// bad index to all ones. The same stream state returns after each last byte.
module ascii_parity_filter_detector_core #(
	parameter int COUNT_BITS = apfd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apfd_pkg::CFG_DATA_W-1:0] cfg_data,
	apfd_in_if.sink                         in_ch,
	apfd_out_if.source                      out_ch
);
	import apfd_pkg::*;

	mode_t                      mode_q;
	kind_t                      kind_q;
	logic                       mid_valid, mid_ready;
	res_t                       mid_res, res_o;
	logic [3:0][COUNT_BITS-1:0] mid_counts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SET;
			kind_q <= KIND_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data);
				REG_KIND: kind_q <= kind_t'(cfg_data);
				default: ;
			endcase
		end
	end

	apfd_byte_unit #(.COUNT_BITS(COUNT_BITS)) u_byte_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.parity_kind  (kind_q),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.byte_in      (in_ch.byte_in),
		.end_of_stream(in_ch.end_of_stream),
		.out_valid    (mid_valid),
		.out_ready    (mid_ready),
		.res          (mid_res),
		.counts       (mid_counts)
	);

	apfd_verdict_pipe #(.COUNT_BITS(COUNT_BITS)) u_verdict_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.res_in   (mid_res),
		.counts   (mid_counts),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.res_out  (res_o)
	);

	assign out_ch.byte_out        = res_o.byte_out;
	assign out_ch.byte_ok         = res_o.byte_ok;
	assign out_ch.verdict         = res_o.verdict;
	assign out_ch.error_total     = res_o.error_total;
	assign out_ch.first_bad_index = res_o.first_bad_index;
	assign out_ch.is_last         = res_o.is_last;

endmodule

// ===== rtl/apfd_checker.sv =====
module apfd_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_last,
	input logic [2:0] verdict
);
	import apfd_pkg::*;

	localparam logic [2:0] DEPTH = 3'd5;

	logic [2:0] occ_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> verdict == V_OK)
		else $error("verdict on a word that is not the last");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH)
		else $error("more words in flight than stages");

	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != 3'd0)
		else $error("result word without an accepted input word");

endmodule

bind ascii_parity_filter_detector_core apfd_props u_apfd_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.is_last  (out_ch.is_last),
	.verdict  (out_ch.verdict)
);

// ===== tb/apfd_checker.sv =====
module apfd_checker
	import apfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	apfd_in_if                    in_ch,
	apfd_out_if                   out_ch,
	output int                    fail_count,
	output int                    in_flight
);

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        byte_ok;
		verdict_t    verdict;
		logic [31:0] error_total;
		logic [31:0] first_bad_index;
		logic        is_last;
	} parity_word_t;

	mode_t        cur_mode;
	kind_t        cur_kind;
	logic [31:0]  class_tally [4];
	logic [31:0]  byte_pos;
	logic [31:0]  err_tally;
	logic [31:0]  first_bad;
	parity_word_t awaited [$];

	function automatic logic [31:0] sat_up(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic kind_accepts(logic [7:0] d, kind_t k);
		case (k)
			KIND_NONE: return !d[7];
			KIND_ODD:  return ^d;
			KIND_EVEN: return !(^d);
			default:   return d[7];
		endcase
	endfunction

	function automatic logic [7:0] with_parity_bit(logic [7:0] d, kind_t k);
		case (k)
			KIND_NONE: return {1'b0, d[6:0]};
			KIND_ODD:  return {~(^d[6:0]), d[6:0]};
			KIND_EVEN: return {^d[6:0], d[6:0]};
			default:   return {1'b1, d[6:0]};
		endcase
	endfunction

	function automatic verdict_t guess_parity();
		longint unsigned c0, c1, c2, c3, total, hi, lo;
		c0 = class_tally[0];
		c1 = class_tally[1];
		c2 = class_tally[2];
		c3 = class_tally[3];
		total = c0 + c1 + c2 + c3;
		hi = total * 85 / 100;
		lo = total * 30 / 100;
		if (c0 + c1 >= hi) return V_NONE;
		if (c0 + c2 >= hi) return V_EVEN;
		if (c2 + c3 >= hi) return V_MARK;
		if (c1 + c3 >= hi) return V_ODD;
		if (c0 + c3 >= hi) return V_ODD;
		if (c1 + c2 >= hi) return V_ODD;
		if (c0 < lo && c1 < lo && c2 < lo && c3 < lo) return V_EIGHT_BIT;
		return V_UNDET;
	endfunction

	function automatic void clear_stream();
		for (int i = 0; i < 4; i++)
			class_tally[i] = '0;
		byte_pos = '0;
		err_tally = '0;
		first_bad = '1;
	endfunction

	function automatic parity_word_t predict(logic [7:0] d, logic eos);
		parity_word_t r;
		logic [1:0]   cls;
		r = '0;
		r.byte_out = d;
		r.byte_ok = kind_accepts(d, cur_kind);
		r.verdict = V_OK;
		cls = {d[7], ^d};
		class_tally[cls] = sat_up(class_tally[cls]);
		if (cur_mode == MODE_CHECK || cur_mode == MODE_FLAG) begin
			if (!r.byte_ok) begin
				if (err_tally == '0)
					first_bad = byte_pos;
				err_tally = sat_up(err_tally);
			end
		end else if (cur_mode == MODE_SET) begin
			r.byte_out = with_parity_bit(d, cur_kind);
		end
		if (eos) begin
			if (cur_mode == MODE_FIND)
				r.verdict = guess_parity();
			else if (cur_mode != MODE_SET)
				r.verdict = (err_tally == '0) ? V_OK : V_ERROR;
		end
		r.error_total = err_tally;
		r.first_bad_index = first_bad;
		r.is_last = eos;
		if (eos)
			clear_stream();
		else
			byte_pos = sat_up(byte_pos);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parity_word_t want;
		if (!arst_n) begin
			cur_mode = MODE_SET;
			cur_kind = KIND_NONE;
			clear_stream();
			awaited.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: cur_mode = mode_t'(cfg_data);
					REG_KIND: cur_kind = kind_t'(cfg_data);
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				awaited.push_back(predict(in_ch.byte_in, in_ch.end_of_stream));
			if (out_ch.valid && out_ch.ready) begin
				if (awaited.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = awaited.pop_front();
					check_field("byte_out", 32'(want.byte_out), 32'(out_ch.byte_out));
					check_field("byte_ok", 32'(want.byte_ok), 32'(out_ch.byte_ok));
					check_field("verdict", 32'(want.verdict), 32'(out_ch.verdict));
					check_field("error_total", want.error_total, out_ch.error_total);
					check_field("first_bad_index", want.first_bad_index,
						out_ch.first_bad_index);
					check_field("is_last", 32'(want.is_last), 32'(out_ch.is_last));
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight <= 0;
		end else begin
			in_flight <= in_flight + int'(in_ch.valid && in_ch.ready)
				- int'(out_ch.valid && out_ch.ready);
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import apfd_pkg::*;

	localparam int ITEMS = 1950;
	localparam int LIMIT = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    in_flight;
	int                    idle_pct;
	int                    stall_pct;
	int                    sent;

	apfd_in_if  in_ch ();
	apfd_out_if out_ch ();

	ascii_parity_filter_detector_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	apfd_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	always #5 clk = ~clk;

	function automatic int pick_idle(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] byte_of_class(logic [1:0] cls);
		logic [7:0] d;
		d = 8'($urandom);
		d[7] = cls[1];
		if ((^d) != cls[0])
			d[0] = ~d[0];
		return d;
	endfunction

	task automatic push_word(input logic [7:0] d, input logic eos);
		int gap;
		gap = pick_idle(idle_pct);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= d;
		in_ch.end_of_stream <= eos;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic load_config(input logic [1:0] which, input mode_t m, input kind_t k);
		if (which[0]) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_MODE;
			cfg_data <= m;
			@(posedge clk);
		end
		if (which[1]) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KIND;
			cfg_data <= k;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
				hold = pick_idle(stall_pct);
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int         stream_left;
		int         phase_left;
		logic [3:0] class_mask;
		logic [1:0] cls;
		logic [7:0] d;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.byte_in = '0;
		in_ch.end_of_stream = 1'b0;
		idle_pct = 30;
		stall_pct = 30;
		stream_left = 0;
		class_mask = 4'hf;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(8'h00, 1'b0);
		push_word(8'hff, 1'b1);
		settle();
		load_config(2'b10, MODE_SET, KIND_ODD);
		push_word(8'h7f, 1'b0);
		push_word(8'h80, 1'b1);
		settle();
		load_config(2'b10, MODE_SET, KIND_EVEN);
		push_word(8'h01, 1'b0);
		push_word(8'hfe, 1'b1);
		settle();
		load_config(2'b10, MODE_SET, KIND_MARK);
		push_word(8'h55, 1'b1);
		settle();
		load_config(2'b11, MODE_CHECK, KIND_EVEN);
		push_word(8'h00, 1'b0);
		push_word(8'h01, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'h03, 1'b1);
		settle();
		load_config(2'b10, MODE_CHECK, KIND_NONE);
		push_word(8'h41, 1'b1);
		settle();
		load_config(2'b11, MODE_FLAG, KIND_ODD);
		push_word(8'h01, 1'b0);
		push_word(8'h00, 1'b1);
		settle();
		load_config(2'b01, MODE_FIND, KIND_ODD);
		push_word(8'h81, 1'b0);
		push_word(8'h82, 1'b0);
		push_word(8'h84, 1'b1);
		push_word(8'h01, 1'b1);

		while (sent < ITEMS) begin
			settle();
			load_config(2'($urandom_range(3)), mode_t'($urandom_range(3)),
				kind_t'($urandom_range(3)));
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 50;
			endcase
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 50;
			endcase
			phase_left = $urandom_range(150, 20);
			while (phase_left > 0 && sent < ITEMS) begin
				if (stream_left == 0) begin
					if ($urandom_range(7) == 0)
						stream_left = $urandom_range(200, 60);
					else
						stream_left = $urandom_range(30, 1);
					class_mask = 4'($urandom_range(15, 1));
				end
				if ($urandom_range(9) == 0) begin
					d = 8'($urandom);
				end else begin
					do cls = 2'($urandom_range(3)); while (!class_mask[cls]);
					d = byte_of_class(cls);
				end
				push_word(d, stream_left == 1);
				stream_left--;
				phase_left--;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/apfd_pkg.sv
rtl/apfd_if.sv
rtl/apfd_byte_unit.sv
rtl/apfd_verdict_pipe.sv
rtl/ascii_parity_filter_detector_core.sv
rtl/apfd_checker.sv
tb/apfd_checker.sv
tb/testbench.sv
